### sv/fbc_pkg.sv
// shared types, register map and cipher functions for the feistel block cipher
`timescale 1ns / 1ps

package fbc_pkg;

   localparam int BLOCK_W = 8;
   localparam int NIB_W   = 4;
   localparam int DATA_W  = 32;
   localparam int ADDR_W  = 4;

   typedef logic [BLOCK_W-1:0] block_type;
   typedef logic [NIB_W-1:0]   nibble_type;

   typedef enum logic [1:0] {
      REG_CIPHER_KEY   = 2'd0,
      REG_INIT_VECTOR  = 2'd1,
      REG_CHAIN_MODE   = 2'd2,
      REG_DECRYPT_MODE = 2'd3
   } reg_index_type;

   typedef struct packed {
      block_type cipher_key;
      block_type init_vector;
      logic      chain_mode;
      logic      decrypt_mode;
   } cfg_type;

   localparam nibble_type SBOX [16] = '{
      4'hE, 4'h4, 4'hD, 4'h1, 4'h2, 4'hF, 4'hB, 4'h8,
      4'h3, 4'hA, 4'h6, 4'hC, 4'h5, 4'h9, 4'h0, 4'h7
   };

   function automatic nibble_type round_f(nibble_type half, nibble_type k);
      return SBOX[half ^ k];
   endfunction

   function automatic block_type encrypt_block(block_type blk, block_type key);
      nibble_type l;
      nibble_type r;
      nibble_type t;
      l = blk[7:4];
      r = blk[3:0];
      t = l ^ round_f(r, key[7:4]);
      l = r;
      r = t;
      t = l ^ round_f(r, key[3:0]);
      l = r;
      r = t;
      return {l, r};
   endfunction

   function automatic block_type decrypt_block(block_type blk, block_type key);
      nibble_type l;
      nibble_type r;
      nibble_type t;
      l = blk[7:4];
      r = blk[3:0];
      // undo round two, then round one
      t = r ^ round_f(l, key[3:0]);
      r = l;
      l = t;
      t = r ^ round_f(l, key[7:4]);
      r = l;
      l = t;
      return {l, r};
   endfunction

endpackage

### sv/fbc_stream_if.sv
// valid/ready stream interfaces for request blocks and response blocks
`timescale 1ns / 1ps

interface fbc_req_if;
   logic                  valid;
   logic                  ready;
   fbc_pkg::block_type    data_in;
   logic                  first_block;

   modport source (output valid, data_in, first_block, input ready);
   modport sink   (input valid, data_in, first_block, output ready);
endinterface

interface fbc_rsp_if;
   logic                  valid;
   logic                  ready;
   fbc_pkg::block_type    data_out;

   modport source (output valid, data_out, input ready);
   modport sink   (input valid, data_out, output ready);
endinterface

### sv/fbc_csr.sv
// apb register file holding key, init vector and mode bits
`timescale 1ns / 1ps

module fbc_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [fbc_pkg::ADDR_W-1:0]  paddr,
   input  logic [fbc_pkg::DATA_W-1:0]  pwdata,
   output logic [fbc_pkg::DATA_W-1:0]  prdata,
   output logic                        pready,
   output fbc_pkg::cfg_type            cfg
);
   import fbc_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign index  = reg_index_type'(paddr[3:2]);
   assign wr_en  = psel && penable && pwrite && pready;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_CIPHER_KEY:   cfg_in.cipher_key   = pwdata[BLOCK_W-1:0];
            REG_INIT_VECTOR:  cfg_in.init_vector  = pwdata[BLOCK_W-1:0];
            REG_CHAIN_MODE:   cfg_in.chain_mode   = pwdata[0];
            REG_DECRYPT_MODE: cfg_in.decrypt_mode = pwdata[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_CIPHER_KEY:   prdata = {{(DATA_W-BLOCK_W){1'b0}}, cfg_ff.cipher_key};
         REG_INIT_VECTOR:  prdata = {{(DATA_W-BLOCK_W){1'b0}}, cfg_ff.init_vector};
         REG_CHAIN_MODE:   prdata = {{(DATA_W-1){1'b0}}, cfg_ff.chain_mode};
         REG_DECRYPT_MODE: prdata = {{(DATA_W-1){1'b0}}, cfg_ff.decrypt_mode};
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### sv/fbc_datapath.sv
// input register, two-round feistel with ecb/cbc chaining, result register
`timescale 1ns / 1ps

module fbc_datapath (
   input  logic               clock,
   input  logic               reset,
   input  fbc_pkg::cfg_type   cfg,
   fbc_req_if.sink            req,
   fbc_rsp_if.source          rsp
);
   import fbc_pkg::*;

   logic      in_valid_ff;
   logic      in_valid_in;
   block_type in_data_ff;
   logic      in_first_ff;
   logic      out_valid_ff;
   logic      out_valid_in;
   block_type out_data_ff;
   block_type chain_ff;
   block_type chain_in;
   logic      out_free;
   logic      advance;
   logic      req_xfer;
   block_type prev;
   block_type result;

   assign out_free  = !out_valid_ff || rsp.ready;
   assign advance   = in_valid_ff && out_free;
   assign req.ready = !in_valid_ff || out_free;
   assign req_xfer  = req.valid && req.ready;

   assign rsp.valid    = out_valid_ff;
   assign rsp.data_out = out_data_ff;

   always_comb begin
      prev   = in_first_ff ? cfg.init_vector : chain_ff;
      result = '0;
      if (!cfg.chain_mode) begin
         result = cfg.decrypt_mode ? decrypt_block(in_data_ff, cfg.cipher_key)
                                   : encrypt_block(in_data_ff, cfg.cipher_key);
      end else if (cfg.decrypt_mode) begin
         result = decrypt_block(in_data_ff, cfg.cipher_key) ^ prev;
      end else begin
         result = encrypt_block(in_data_ff ^ prev, cfg.cipher_key);
      end
   end

   always_comb begin
      in_valid_in  = req_xfer || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp.ready);
      chain_in     = chain_ff;
      if (advance && cfg.chain_mode) begin
         chain_in = cfg.decrypt_mode ? in_data_ff : result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         chain_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         chain_ff     <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_data_ff  <= req.data_in;
         in_first_ff <= req.first_block;
      end
      if (advance) begin
         out_data_ff <= result;
      end
   end

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> in_valid_ff)
      else $error("accepted block not held in input register");

   a_ecb_chain_hold: assert property (@(posedge clock) disable iff (reset)
      (advance && !cfg.chain_mode) |=> $stable(chain_ff))
      else $error("chain register changed in ecb mode");

   a_cbc_enc_chain: assert property (@(posedge clock) disable iff (reset)
      (advance && cfg.chain_mode && !cfg.decrypt_mode) |=> (chain_ff == out_data_ff))
      else $error("cbc encrypt chain differs from ciphertext");

   a_cbc_dec_chain: assert property (@(posedge clock) disable iff (reset)
      (advance && cfg.chain_mode && cfg.decrypt_mode) |=> (chain_ff == $past(in_data_ff)))
      else $error("cbc decrypt chain differs from input block");

   a_out_drop: assert property (@(posedge clock) disable iff (reset)
      $fell(out_valid_ff) |-> $past(rsp.ready))
      else $error("result dropped without transfer");

endmodule

### sv/feistel_block_cipher_ecb_cbc_top.sv
// top level: one block in, one block out, two-stage registered feistel datapath
// datapath: an accepted block is held in the input register, ciphered into the result register, and offered from there
// throughput: one block per cycle while the response side is ready, also in cbc mode, set by the single cipher stage
// reset: synchronous active high; clears the config registers, the chain block and both valids
// no clearing pass; blocks are accepted in the cycle after reset is released
`timescale 1ns / 1ps

module feistel_block_cipher_ecb_cbc_top (
   input  logic                        clock,
   input  logic                        reset,
   fbc_req_if.sink                     req,
   fbc_rsp_if.source                   rsp,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [fbc_pkg::ADDR_W-1:0]  paddr,
   input  logic [fbc_pkg::DATA_W-1:0]  pwdata,
   output logic [fbc_pkg::DATA_W-1:0]  prdata,
   output logic                        pready
);
   import fbc_pkg::*;

   cfg_type cfg;

   fbc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   fbc_datapath u_datapath (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .req   (req),
      .rsp   (rsp)
   );

endmodule

### tb/tb_feistel_block_cipher_ecb_cbc_top.sv
// self-checking testbench for the feistel block cipher top: ecb and cbc, encrypt and decrypt
`timescale 1ns / 1ps

module tb_feistel_block_cipher_ecb_cbc_top;
   import fbc_pkg::*;

   localparam int PIPE_CYCLES   = 2;
   localparam int HOLD_CYCLES   = 150;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_BLOCKS  = 125;
   localparam int IDLE_MIX [4]  = '{0, 15, 40, 70};
   localparam nibble_type SUBST [16] = '{
      4'hE, 4'h4, 4'hD, 4'h1, 4'h2, 4'hF, 4'hB, 4'h8,
      4'h3, 4'hA, 4'h6, 4'hC, 4'h5, 4'h9, 4'h0, 4'h7
   };

   logic              clock;
   logic              reset;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   fbc_req_if req_bus ();
   fbc_rsp_if rsp_bus ();

   feistel_block_cipher_ecb_cbc_top uut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus),
      .rsp     (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // predictor copy of the registers and the chain
   block_type key_cfg;
   block_type iv_cfg;
   logic      chain_cfg;
   logic      decrypt_cfg;
   block_type chain_val;

   block_type pending_blocks [$];

   int errors;
   int blocks_sent;
   int cbc_blocks;
   int decrypt_blocks;
   int blocks_checked;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_req;
   int hold_seen;
   int hold_left;
   int stall_left;

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
   endfunction

   function automatic block_type feistel_fwd(block_type blk, block_type key);
      nibble_type rk [2];
      nibble_type l;
      nibble_type r;
      nibble_type t;
      rk[0] = key[7:4];
      rk[1] = key[3:0];
      {l, r} = blk;
      for (int i = 0; i < 2; i++) begin
         t = l ^ SUBST[r ^ rk[i]];
         l = r;
         r = t;
      end
      return {l, r};
   endfunction

   function automatic block_type feistel_inv(block_type blk, block_type key);
      nibble_type rk [2];
      nibble_type l;
      nibble_type r;
      nibble_type t;
      rk[0] = key[7:4];
      rk[1] = key[3:0];
      {l, r} = blk;
      for (int i = 1; i >= 0; i--) begin
         t = r ^ SUBST[l ^ rk[i]];
         r = l;
         l = t;
      end
      return {l, r};
   endfunction

   // expected output block; advances the chain in cbc mode
   function automatic block_type cipher_predict(block_type blk, logic first);
      block_type prev;
      block_type res;
      if (!chain_cfg) begin
         return decrypt_cfg ? feistel_inv(blk, key_cfg) : feistel_fwd(blk, key_cfg);
      end
      prev = first ? iv_cfg : chain_val;
      if (decrypt_cfg) begin
         res = feistel_inv(blk, key_cfg) ^ prev;
         chain_val = blk;
      end else begin
         res = feistel_fwd(blk ^ prev, key_cfg);
         chain_val = res;
      end
      return res;
   endfunction

   function automatic logic [DATA_W-1:0] reg_value(reg_index_type idx);
      case (idx)
         REG_CIPHER_KEY:  return DATA_W'(key_cfg);
         REG_INIT_VECTOR: return DATA_W'(iv_cfg);
         REG_CHAIN_MODE:  return DATA_W'(chain_cfg);
         default:         return DATA_W'(decrypt_cfg);
      endcase
   endfunction

   function automatic void report_mismatch(string what, logic [DATA_W-1:0] exp_val,
                                           logic [DATA_W-1:0] got_val);
      errors++;
      if (errors <= 10)
         $display("mismatch on %s: expected %h, got %h at %0t", what, exp_val, got_val,
                  $realtime);
   endfunction

   // response checker
   always @(posedge clock) begin
      block_type exp_blk;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         blocks_checked++;
         if (pending_blocks.size() == 0) begin
            report_mismatch("unexpected response", '0, DATA_W'(rsp_bus.data_out));
         end else begin
            exp_blk = pending_blocks.pop_front();
            if (rsp_bus.data_out !== exp_blk)
               report_mismatch("data_out", DATA_W'(exp_blk), DATA_W'(rsp_bus.data_out));
         end
      end
   end

   // response ready: random stalls plus a long hold on request
   always @(posedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen = hold_req;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
         if ($urandom_range(0, 99) < recv_idle_pct)
            stall_left = pick_gap();
      end
   end

   task automatic apb_xfer(input logic wr, input reg_index_type idx,
                           input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {idx, 2'b00};
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // write a register with junk above the field, then read it back
   task automatic configure(input reg_index_type idx, input block_type val);
      logic [DATA_W-1:0] wdata;
      logic [DATA_W-1:0] rdata;
      wdata = $urandom();
      case (idx)
         REG_CIPHER_KEY: begin
            wdata[7:0] = val;
            key_cfg = val;
         end
         REG_INIT_VECTOR: begin
            wdata[7:0] = val;
            iv_cfg = val;
         end
         REG_CHAIN_MODE: begin
            wdata[0] = val[0];
            chain_cfg = val[0];
         end
         default: begin
            wdata[0] = val[0];
            decrypt_cfg = val[0];
         end
      endcase
      apb_xfer(1'b1, idx, wdata, rdata);
      apb_xfer(1'b0, idx, $urandom(), rdata);
      if (rdata !== reg_value(idx))
         report_mismatch(idx.name(), reg_value(idx), rdata);
   endtask

   task automatic send_block(input block_type d, input logic first);
      int gap;
      gap = ($urandom_range(0, 99) < send_idle_pct) ? pick_gap() : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.data_in     <= d;
      req_bus.first_block <= first;
      do @(posedge clock); while (!req_bus.ready);
      pending_blocks.push_back(cipher_predict(d, first));
      blocks_sent++;
      if (chain_cfg)
         cbc_blocks++;
      if (decrypt_cfg)
         decrypt_blocks++;
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_blocks.size() != 0);
   endtask

   // cbc straight out of reset chains from a zero block until a first block
   task automatic test_cbc_from_reset();
      configure(REG_CHAIN_MODE, 8'd1);
      send_block(8'h00, 1'b0);
      send_block(8'hFF, 1'b0);
      send_block(8'h3C, 1'b0);
      send_block(8'h3C, 1'b1);
      drain();
   endtask

   task automatic test_ecb_extremes();
      configure(REG_CHAIN_MODE, 8'd0);
      configure(REG_CIPHER_KEY, 8'hFF);
      for (int m = 0; m < 2; m++) begin
         configure(REG_DECRYPT_MODE, block_type'(m));
         send_block(8'h00, 1'b1);
         send_block(8'hFF, 1'b0);
         send_block(8'h0F, 1'b1);
         send_block(8'hF0, 1'b0);
         drain();
      end
   endtask

   task automatic test_cbc_decrypt();
      configure(REG_CIPHER_KEY, 8'h5A);
      configure(REG_INIT_VECTOR, 8'hFF);
      configure(REG_CHAIN_MODE, 8'd1);
      configure(REG_DECRYPT_MODE, 8'd1);
      send_block(8'h00, 1'b1);
      send_block(8'hFF, 1'b0);
      send_block(8'h81, 1'b0);
      send_block(8'h7E, 1'b1);
      drain();
   endtask

   // ecb blocks in the middle of a cbc message leave the chain alone
   task automatic test_ecb_keeps_chain();
      configure(REG_DECRYPT_MODE, 8'd0);
      configure(REG_INIT_VECTOR, 8'hA5);
      configure(REG_CIPHER_KEY, 8'hC3);
      send_block(8'h12, 1'b1);
      send_block(8'h34, 1'b0);
      send_block(8'h56, 1'b0);
      drain();
      configure(REG_CHAIN_MODE, 8'd0);
      send_block(8'h78, 1'b1);
      send_block(8'h9A, 1'b1);
      drain();
      configure(REG_CHAIN_MODE, 8'd1);
      send_block(8'hBC, 1'b0);
      send_block(8'hDE, 1'b0);
      drain();
   endtask

   task automatic test_random_messages();
      int sent;
      int len;
      logic first;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         send_idle_pct = IDLE_MIX[p % 4];
         recv_idle_pct = IDLE_MIX[(p + p / 4) % 4];
         configure(REG_CIPHER_KEY, (p == 0) ? 8'h00 : (p == 1) ? 8'hFF :
                   block_type'($urandom_range(0, 255)));
         configure(REG_INIT_VECTOR, (p == 2) ? 8'h00 : (p == 3) ? 8'hFF :
                   block_type'($urandom_range(0, 255)));
         configure(REG_CHAIN_MODE, block_type'(p % 2));
         configure(REG_DECRYPT_MODE, block_type'((p / 2) % 2));
         sent = 0;
         while (sent < PHASE_BLOCKS) begin
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++) begin
               first = (i == 0);
               if ($urandom_range(0, 99) < 15)
                  first = 1'($urandom_range(0, 1));
               send_block(block_type'($urandom_range(0, 255)), first);
            end
            sent += len;
         end
         drain();
      end
   endtask

   // receiver holds off while the sender keeps offering back to back
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      configure(REG_CHAIN_MODE, 8'd1);
      configure(REG_DECRYPT_MODE, 8'd0);
      hold_req <= hold_req + 1;
      for (int i = 0; i < 40; i++)
         send_block(block_type'($urandom_range(0, 255)), (i % 10) == 0);
      drain();
   endtask

   initial begin
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.data_in     <= '0;
      req_bus.first_block <= 1'b0;
      psel                <= 1'b0;
      penable             <= 1'b0;
      pwrite              <= 1'b0;
      paddr               <= '0;
      pwdata              <= '0;
      key_cfg     = '0;
      iv_cfg      = '0;
      chain_cfg   = 1'b0;
      decrypt_cfg = 1'b0;
      chain_val   = '0;
      send_idle_pct = 20;
      recv_idle_pct = 20;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_cbc_from_reset();
      test_ecb_extremes();
      test_cbc_decrypt();
      test_ecb_keeps_chain();
      test_random_messages();
      test_backpressure();
      drain();
      repeat (PIPE_CYCLES + 6) @(posedge clock);
      $display("%0d blocks sent, %0d checked: %0d chained, %0d decrypted",
               blocks_sent, blocks_checked, cbc_blocks, decrypt_blocks);
      $display("%0d random phases over key, vector and both modes, one long output hold",
               RANDOM_PHASES);
      if (errors == 0) begin
         $display("tb_feistel_block_cipher_ecb_cbc_top: clean");
      end else begin
         $display("tb_feistel_block_cipher_ecb_cbc_top: errors");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout with %0d responses outstanding", pending_blocks.size());
      $display("tb_feistel_block_cipher_ecb_cbc_top: errors");
      $finish;
   end

endmodule
